[design/assert_macros.svh]
// assertion macros shared by the rotation core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

[design/var_pkg.sv]
// types and constants for the axis-angle rotation core
// no dependencies
`default_nettype none
package var_pkg;
  localparam int CordicSteps = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;

  typedef logic signed [15:0] q12_t;
  typedef logic signed [16:0] bq_t;
  typedef logic signed [33:0] cw_t;

  // item as it travels from the front part to the back part
  // b reaches +2^15 for the most negative axis code, hence one extra bit
  typedef struct packed {
    q12_t vx;
    q12_t vy;
    q12_t vz;
    q12_t s;
    bq_t  bx;
    bq_t  by;
    bq_t  bz;
  } rot_item_t;

  function automatic cw_t atan_entry(input int i);
    case (i)
      0: atan_entry = 34'sd536870912;
      1: atan_entry = 34'sd316933406;
      2: atan_entry = 34'sd167458907;
      3: atan_entry = 34'sd85004756;
      4: atan_entry = 34'sd42667331;
      5: atan_entry = 34'sd21354465;
      6: atan_entry = 34'sd10679838;
      7: atan_entry = 34'sd5340245;
      8: atan_entry = 34'sd2670163;
      9: atan_entry = 34'sd1335087;
      10: atan_entry = 34'sd667544;
      11: atan_entry = 34'sd333772;
      12: atan_entry = 34'sd166886;
      13: atan_entry = 34'sd83443;
      14: atan_entry = 34'sd41722;
      15: atan_entry = 34'sd20861;
      16: atan_entry = 34'sd10430;
      17: atan_entry = 34'sd5215;
      18: atan_entry = 34'sd2608;
      19: atan_entry = 34'sd1304;
      20: atan_entry = 34'sd652;
      21: atan_entry = 34'sd326;
      22: atan_entry = 34'sd163;
      23: atan_entry = 34'sd81;
      default: atan_entry = '0;
    endcase
  endfunction

  // round q2.30 to q1.14 and clamp to +-1
  function automatic q12_t to_q14(input cw_t v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    t = 35'(v) + 35'sd32768;
    r = t[34:16];
    if (r > 19'sd16384) to_q14 = 16'sd16384;
    else if (r < -19'sd16384) to_q14 = -16'sd16384;
    else to_q14 = r[15:0];
  endfunction
endpackage
`default_nettype wire

[design/vector_axis_angle_rotation_core.sv]
// channel | ports                              | beat
// input   | in_push in_full in_vec_* in_axis_* | push & !full
// output  | out_empty out_pop out_*            | pop & !empty
// one item per cycle sustained while in_full is low; stages: input register,
// 24 cordic, 1 axis scale, 3 product, 1 queue write
// the pipeline always advances; a 64-entry result queue absorbs items in flight
// full rises once queue plus in-flight items reach one below its depth
// rst_n synchronous; clears pipeline valids and queue pointers
// depends on var_pkg, var_front, var_back, var_fifo, assert_macros.svh
`include "assert_macros.svh"
`default_nettype none
module vector_axis_angle_rotation_core import var_pkg::*; #(
  parameter int QueueDepth = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire q12_t in_vec_x,
  input  wire q12_t in_vec_y,
  input  wire q12_t in_vec_z,
  input  wire q12_t in_axis_x,
  input  wire q12_t in_axis_y,
  input  wire q12_t in_axis_z,
  input  wire logic [15:0] in_turn_angle,
  output logic      out_empty,
  input  wire logic out_pop,
  output q12_t      out_x,
  output q12_t      out_y,
  output q12_t      out_z,
  output logic      out_clipped
);
  localparam int Lat = CordicSteps + 5;
  localparam int CW = $clog2(QueueDepth+1);
  logic acc, fv, bv, rd;
  rot_item_t fi;
  q12_t bx, by, bz;
  logic bc;
  logic [CW-1:0] cnt;
  logic [CW-1:0] infl_r;

  assign acc = in_push && !in_full;
  assign rd = out_pop && !out_empty;

  var_front u_front (.clk, .rst_n, .en(1'b1), .in_valid(acc),
    .vx(in_vec_x), .vy(in_vec_y), .vz(in_vec_z),
    .ax(in_axis_x), .ay(in_axis_y), .az(in_axis_z), .ang(in_turn_angle),
    .out_valid(fv), .out_item(fi));
  var_back u_back (.clk, .rst_n, .en(1'b1), .in_valid(fv), .in_item(fi),
    .out_valid(bv), .ox(bx), .oy(by), .oz(bz), .oclip(bc));
  var_fifo #(.Depth(QueueDepth)) u_fifo (.clk, .rst_n, .wr(bv), .wx(bx), .wy(by),
    .wz(bz), .wc(bc), .rd, .empty(out_empty), .count(cnt),
    .rx(out_x), .ry(out_y), .rz(out_z), .rc(out_clipped));

  // items inside the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) infl_r <= '0;
    else infl_r <= infl_r + (acc ? 1'b1 : 1'b0) - (bv ? 1'b1 : 1'b0);
  end
  assign in_full = (32'(infl_r) + 32'(cnt)) >= 32'(QueueDepth - 1);

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, bv && !rd && (32'(cnt) == QueueDepth),
    "result queue overflow")
  `ASSERT_IMPL(a_infl_bound, clk, rst_n, 32'(infl_r) <= Lat, "in-flight count too large")
  `ASSERT_IMPL(a_full_blocks, clk, rst_n, in_full |-> !acc, "accept while full")
endmodule
`default_nettype wire

[design/var_front.sv]
// front part: 24-stage pipelined cordic for the half angle and axis scaling
// depends on var_pkg
`default_nettype none
module var_front import var_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire q12_t      vx,
  input  wire q12_t      vy,
  input  wire q12_t      vz,
  input  wire q12_t      ax,
  input  wire q12_t      ay,
  input  wire q12_t      az,
  input  wire logic [15:0] ang,
  output logic           out_valid,
  output rot_item_t      out_item
);
  localparam int N = CordicSteps;
  cw_t x_r [N+1];
  cw_t y_r [N+1];
  cw_t z_r [N+1];
  logic [N+1:0] v_r;
  q12_t pv_r [N+1][6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CordicGain;
      y_r[0] <= '0;
      z_r[0] <= 34'({ang, 15'd0}) - QuarterTurn;
      pv_r[0][0] <= vx; pv_r[0][1] <= vy; pv_r[0][2] <= vz;
      pv_r[0][3] <= ax; pv_r[0][4] <= ay; pv_r[0][5] <= az;
      for (int i = 0; i < N; i++) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end
        pv_r[i+1] <= pv_r[i];
      end
    end
  end

  // scale axis by -cos z, round to q.14
  q12_t sh;
  logic signed [31:0] p [3];
  logic signed [31:0] pr [3];
  always_comb begin
    sh = -to_q14(x_r[N]);
    for (int j = 0; j < 3; j++) begin
      p[j] = pv_r[N][3+j] * sh;
      pr[j] = (p[j] + 32'sd8192) >>> 14;
    end
  end

  rot_item_t item_r;
  always_ff @(posedge clk) begin
    if (en) begin
      item_r.vx <= pv_r[N][0];
      item_r.vy <= pv_r[N][1];
      item_r.vz <= pv_r[N][2];
      item_r.s  <= -to_q14(y_r[N]);
      item_r.bx <= pr[0][16:0];
      item_r.by <= pr[1][16:0];
      item_r.bz <= pr[2][16:0];
    end
  end
  assign out_item = item_r;
  assign out_valid = v_r[N+1];
endmodule
`default_nettype wire

[design/var_back.sv]
// back part: rotor sandwich product, rounding and saturation, 3 stages
// depends on var_pkg
`default_nettype none
module var_back import var_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire rot_item_t in_item,
  output logic           out_valid,
  output q12_t           ox,
  output q12_t           oy,
  output q12_t           oz,
  output logic           oclip
);
  logic [2:0] v_r;
  logic signed [33:0] cr_r [3];
  logic signed [31:0] bb_r [3];
  logic signed [31:0] bv_r [3];
  logic signed [31:0] ss_r;
  q12_t v2_r [3];
  bq_t b2_r [3];
  q12_t s2_r;
  logic signed [51:0] t_r [3][3];
  logic signed [15:0] o_r [3];
  logic clip_r;

  q12_t vv [3];
  bq_t bq [3];
  assign vv[0] = in_item.vx; assign vv[1] = in_item.vy; assign vv[2] = in_item.vz;
  assign bq[0] = in_item.bx; assign bq[1] = in_item.by; assign bq[2] = in_item.bz;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[1:0], in_valid};
  end

  logic signed [53:0] acc [3];
  logic signed [25:0] rq [3];
  logic cl [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = 54'(t_r[j][0]) - 54'sd2 * (54'(t_r[j][1]) - 54'(t_r[j][2]));
      rq[j] = 26'((acc[j] + 54'sd134217728) >>> 28);
      cl[j] = (rq[j] > 26'sd32767) || (rq[j] < -26'sd32768);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: products of b with v and b, and of s with itself
      s2_r <= in_item.s;
      ss_r <= in_item.s * in_item.s;
      for (int j = 0; j < 3; j++) begin
        v2_r[j] <= vv[j];
        b2_r[j] <= bq[j];
        bb_r[j] <= bq[j] * bq[j];
        bv_r[j] <= bq[j] * vv[j];
      end
      cr_r[0] <= bq[1] * vv[2] - bq[2] * vv[1];
      cr_r[1] <= bq[2] * vv[0] - bq[0] * vv[2];
      cr_r[2] <= bq[0] * vv[1] - bq[1] * vv[0];
      // stage 2: sums and outer products
      for (int j = 0; j < 3; j++) begin
        t_r[j][0] <= 52'((34'(ss_r) - 34'(bb_r[0]) - 34'(bb_r[1]) - 34'(bb_r[2]))
                         * v2_r[j]);
        t_r[j][1] <= 52'(s2_r * cr_r[j]);
        t_r[j][2] <= 52'((34'(bv_r[0]) + 34'(bv_r[1]) + 34'(bv_r[2])) * b2_r[j]);
      end
      // stage 3: round and saturate
      for (int j = 0; j < 3; j++) begin
        o_r[j] <= cl[j] ? (rq[j][25] ? -16'sd32768 : 16'sd32767) : rq[j][15:0];
      end
      clip_r <= cl[0] | cl[1] | cl[2];
    end
  end
  assign out_valid = v_r[2];
  assign ox = o_r[0];
  assign oy = o_r[1];
  assign oz = o_r[2];
  assign oclip = clip_r;
endmodule
`default_nettype wire

[design/var_fifo.sv]
// result queue with credit slack for the non-stalling pipeline
// depends on var_pkg
`default_nettype none
module var_fifo import var_pkg::*; #(
  parameter int Depth = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire q12_t wx,
  input  wire q12_t wy,
  input  wire q12_t wz,
  input  wire logic wc,
  input  wire logic rd,
  output logic      empty,
  output logic [$clog2(Depth+1)-1:0] count,
  output q12_t      rx,
  output q12_t      ry,
  output q12_t      rz,
  output logic      rc
);
  localparam int AW = $clog2(Depth);
  logic [48:0] mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW-1:0] rp_nxt;
  logic [$clog2(Depth+1)-1:0] cnt_r;
  logic [48:0] head_r;

  always_comb begin
    rp_nxt = rp_r;
    if (rd) rp_nxt = (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      rp_r <= rp_nxt;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

  // head is fetched ahead; a beat written into the next head slot bypasses the array
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= {wc, wz, wy, wx};
    if (wr && (wp_r == rp_nxt)) head_r <= {wc, wz, wy, wx};
    else head_r <= mem[rp_nxt];
  end

  assign rx = head_r[15:0];
  assign ry = head_r[31:16];
  assign rz = head_r[47:32];
  assign rc = head_r[48];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule
`default_nettype wire
